// ===== design/twi_mc_pkg.sv =====
`timescale 1ns / 1ps

package twi_mc_pkg;

   // Receive store sizing
   localparam int RX_DEPTH = 16;
   localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
   localparam int RX_IDX_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

   // Item kinds carried in tuser
   localparam logic [2:0] MODE_READ  = 3'd0;
   localparam logic [2:0] MODE_WRITE = 3'd1;
   localparam logic [2:0] MODE_TICK  = 3'd2;
   localparam logic [2:0] MODE_LOAD  = 3'd3;
   localparam logic [2:0] MODE_QUERY = 3'd4;

   // Register indexes
   localparam logic [7:0] REG_RATE    = 8'd0;
   localparam logic [7:0] REG_STATUS  = 8'd1;
   localparam logic [7:0] REG_OWN     = 8'd2;
   localparam logic [7:0] REG_DATA    = 8'd3;
   localparam logic [7:0] REG_CONTROL = 8'd4;
   localparam logic [7:0] REG_MASK    = 8'd5;

   // Control register bit positions
   localparam int CTL_TWINT = 7;
   localparam int CTL_TWEA  = 6;
   localparam int CTL_TWSTA = 5;
   localparam int CTL_TWSTO = 4;
   localparam int CTL_TWEN  = 2;
   localparam int CTL_TWIE  = 0;

   // Bus status codes
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_REP_START  = 8'h10;
   localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
   localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
   localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
   localparam logic [7:0] ST_SLA_R_NACK = 8'h48;
   localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
   localparam logic [7:0] ST_DATA_R_NAK = 8'h58;
   localparam logic [7:0] ST_IDLE       = 8'hF8;

   localparam logic [7:0]  RESET_DATA     = 8'hFF;
   localparam logic [15:0] PERIOD_BASE    = 16'd16;

   typedef enum logic [1:0] {
      BM_IDLE = 2'd0,
      BM_MTX  = 2'd1,
      BM_MRX  = 2'd2
   } bus_mode_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  target;
      logic [7:0]  write_data;
      logic [15:0] elapsed;
      logic        power_reduced;
      logic        rx_restart;
   } item_type;

   typedef struct packed {
      logic [7:0] reg_value;
      logic       irq_request;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       slave_match;
      logic       busy_res;
   } result_type;

   typedef struct packed {
      logic       load;
      logic       restart;
      logic       pop;
      logic [7:0] data;
   } rx_ctrl_type;

   typedef struct packed {
      logic       avail;
      logic [7:0] head;
   } rx_stat_type;

   // New status code in bits 7..3, prescaler bits kept
   function automatic logic [7:0] with_code(input logic [7:0] code, input logic [7:0] status);
      with_code = {code[7:3], 1'b0, status[1:0]};
   endfunction

endpackage

// ===== design/twi_mc_rx_store.sv =====
`timescale 1ns / 1ps

module twi_mc_rx_store (
   input  logic                     clock,
   input  logic                     reset,
   input  twi_mc_pkg::rx_ctrl_type  rx_ctrl,
   output twi_mc_pkg::rx_stat_type  rx_stat
);

   logic [7:0] store_ff [0:twi_mc_pkg::RX_DEPTH-1];
   logic [7:0] head_ff;

   logic [twi_mc_pkg::RX_CNT_W-1:0] count_ff, count_in;
   logic [twi_mc_pkg::RX_CNT_W-1:0] pos_ff, pos_in;
   logic [twi_mc_pkg::RX_CNT_W-1:0] count_base;
   logic                            room;

   // Restart empties the store before the load
   assign count_base = rx_ctrl.restart ? '0 : count_ff;
   assign room = count_base < twi_mc_pkg::RX_CNT_W'(twi_mc_pkg::RX_DEPTH);

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      if (rx_ctrl.load) begin
         if (rx_ctrl.restart) begin
            pos_in = '0;
         end
         count_in = room ? count_base + 1'b1 : count_base;
      end else if (rx_ctrl.pop) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

   // Store entries carry no reset; head byte fetched for the next read position,
   // a load into that very slot passes straight through
   always_ff @(posedge clock) begin
      if (rx_ctrl.load && room) begin
         store_ff[count_base[twi_mc_pkg::RX_IDX_W-1:0]] <= rx_ctrl.data;
      end
      if (rx_ctrl.load && room && (count_base == pos_in)) begin
         head_ff <= rx_ctrl.data;
      end else begin
         head_ff <= store_ff[pos_in[twi_mc_pkg::RX_IDX_W-1:0]];
      end
   end

   // Head byte is only used while unread bytes remain
   assign rx_stat.avail = (pos_ff < count_ff) &&
                          (pos_ff < twi_mc_pkg::RX_CNT_W'(twi_mc_pkg::RX_DEPTH));
   assign rx_stat.head  = head_ff;

endmodule

// ===== design/twi_mc_engine.sv =====
`timescale 1ns / 1ps

module twi_mc_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  twi_mc_pkg::item_type     item,
   input  twi_mc_pkg::rx_stat_type  rx_stat,
   output twi_mc_pkg::rx_ctrl_type  rx_ctrl,
   output twi_mc_pkg::result_type   result
);

   logic [7:0]  bit_rate_ff, bit_rate_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  own_ff, own_in;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  control_ff, control_in;
   logic [7:0]  mask_ff, mask_in;
   logic [15:0] cycles_ff, cycles_in;
   logic        irq_ff, irq_in;
   twi_mc_pkg::bus_mode_type bus_mode_ff, bus_mode_in;

   logic [7:0]  reg_value;
   logic        sent;
   logic        match;
   logic [15:0] reload;
   logic [7:0]  code;

   // Bit period: 16 + 2 * rate * 4^prescaler
   assign reload = twi_mc_pkg::PERIOD_BASE +
                   ({8'h00, bit_rate_ff} << {status_ff[1:0], 1'b1});
   assign code = {status_ff[7:3], 3'b000};

   // Next state
   always_comb begin
      bit_rate_in = bit_rate_ff;
      status_in   = status_ff;
      own_in      = own_ff;
      data_in     = data_ff;
      control_in  = control_ff;
      mask_in     = mask_ff;
      cycles_in   = cycles_ff;
      irq_in      = irq_ff;
      bus_mode_in = bus_mode_ff;
      rx_ctrl     = '0;
      rx_ctrl.data = item.write_data;
      reg_value   = 8'h00;
      sent        = 1'b0;
      match       = 1'b0;
      if (fire) begin
         unique case (item.mode)
            twi_mc_pkg::MODE_READ: begin
               unique case (item.target)
                  twi_mc_pkg::REG_RATE:    reg_value = bit_rate_ff;
                  twi_mc_pkg::REG_STATUS:  reg_value = status_ff;
                  twi_mc_pkg::REG_OWN:     reg_value = own_ff;
                  twi_mc_pkg::REG_DATA:    reg_value = data_ff;
                  twi_mc_pkg::REG_CONTROL: reg_value = {irq_ff, control_ff[6:0]};
                  twi_mc_pkg::REG_MASK:    reg_value = mask_ff;
                  default:                 reg_value = 8'h00;
               endcase
            end
            twi_mc_pkg::MODE_WRITE: begin
               unique case (item.target)
                  twi_mc_pkg::REG_RATE:   bit_rate_in = item.write_data;
                  twi_mc_pkg::REG_STATUS: status_in = {status_ff[7:2], item.write_data[1:0]};
                  twi_mc_pkg::REG_OWN:    own_in = item.write_data;
                  twi_mc_pkg::REG_DATA:   data_in = item.write_data;
                  twi_mc_pkg::REG_CONTROL: begin
                     if (item.write_data[twi_mc_pkg::CTL_TWINT]) begin
                        irq_in = 1'b0;
                        if (item.write_data[twi_mc_pkg::CTL_TWEN]) begin
                           cycles_in = reload;
                        end
                     end
                     control_in = {1'b0, item.write_data[6:0]};
                  end
                  twi_mc_pkg::REG_MASK:   mask_in = item.write_data;
                  default: ;
               endcase
            end
            twi_mc_pkg::MODE_TICK: begin
               if (!item.power_reduced && (cycles_ff != 16'd0)) begin
                  if (item.elapsed >= cycles_ff) begin
                     cycles_in = 16'd0;
                     // One bus step completes
                     priority if (control_ff[twi_mc_pkg::CTL_TWSTA]) begin
                        bus_mode_in = twi_mc_pkg::BM_MTX;
                        status_in = twi_mc_pkg::with_code(
                           (bus_mode_ff == twi_mc_pkg::BM_IDLE) ?
                           twi_mc_pkg::ST_START : twi_mc_pkg::ST_REP_START, status_ff);
                        control_in[twi_mc_pkg::CTL_TWSTA] = 1'b0;
                        irq_in = 1'b1;
                     end else if (control_ff[twi_mc_pkg::CTL_TWSTO]) begin
                        // STOP leaves the interrupt flag alone
                        bus_mode_in = twi_mc_pkg::BM_IDLE;
                        status_in = twi_mc_pkg::with_code(twi_mc_pkg::ST_IDLE, status_ff);
                        control_in[twi_mc_pkg::CTL_TWSTO] = 1'b0;
                     end else begin
                        irq_in = 1'b1;
                        priority if ((bus_mode_ff != twi_mc_pkg::BM_IDLE) &&
                                     ((code == twi_mc_pkg::ST_START) ||
                                      (code == twi_mc_pkg::ST_REP_START))) begin
                           // Address phase, direction from data bit 0
                           if (data_ff[0]) begin
                              bus_mode_in = twi_mc_pkg::BM_MRX;
                              status_in = twi_mc_pkg::with_code(rx_stat.avail ?
                                 twi_mc_pkg::ST_SLA_R_ACK : twi_mc_pkg::ST_SLA_R_NACK,
                                 status_ff);
                           end else begin
                              bus_mode_in = twi_mc_pkg::BM_MTX;
                              status_in = twi_mc_pkg::with_code(twi_mc_pkg::ST_SLA_W_ACK,
                                                               status_ff);
                           end
                        end else if (bus_mode_ff == twi_mc_pkg::BM_MTX) begin
                           status_in = twi_mc_pkg::with_code(twi_mc_pkg::ST_DATA_W_ACK,
                                                            status_ff);
                           sent = 1'b1;
                        end else if (bus_mode_ff == twi_mc_pkg::BM_MRX) begin
                           if (rx_stat.avail) begin
                              data_in = rx_stat.head;
                              rx_ctrl.pop = 1'b1;
                              status_in = twi_mc_pkg::with_code(
                                 control_ff[twi_mc_pkg::CTL_TWEA] ?
                                 twi_mc_pkg::ST_DATA_R_ACK : twi_mc_pkg::ST_DATA_R_NAK,
                                 status_ff);
                           end else begin
                              status_in = twi_mc_pkg::with_code(twi_mc_pkg::ST_DATA_R_NAK,
                                                               status_ff);
                           end
                        end else begin
                           // Idle with nothing to do: flag only
                        end
                     end
                  end else begin
                     cycles_in = cycles_ff - item.elapsed;
                  end
               end
            end
            twi_mc_pkg::MODE_LOAD: begin
               rx_ctrl.load    = 1'b1;
               rx_ctrl.restart = item.rx_restart;
            end
            twi_mc_pkg::MODE_QUERY: begin
               // 7-bit address under mask, or general call
               match = (((item.target[7:1] ^ own_ff[7:1]) & ~mask_ff[7:1]) == 7'd0) ||
                       ((item.target == 8'h00) && own_ff[0]);
            end
            default: ;
         endcase
      end
   end

   // Result fields
   always_comb begin
      result.reg_value   = reg_value;
      result.irq_request = irq_in && control_in[twi_mc_pkg::CTL_TWIE];
      result.tx_valid    = sent;
      result.tx_byte     = sent ? data_ff : 8'h00;
      result.slave_match = match;
      result.busy_res    = cycles_in != 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_rate_ff <= 8'h00;
         status_ff   <= twi_mc_pkg::ST_IDLE;
         own_ff      <= 8'h00;
         data_ff     <= twi_mc_pkg::RESET_DATA;
         control_ff  <= 8'h00;
         mask_ff     <= 8'h00;
         cycles_ff   <= 16'd0;
         irq_ff      <= 1'b0;
         bus_mode_ff <= twi_mc_pkg::BM_IDLE;
      end else begin
         bit_rate_ff <= bit_rate_in;
         status_ff   <= status_in;
         own_ff      <= own_in;
         data_ff     <= data_in;
         control_ff  <= control_in;
         mask_ff     <= mask_in;
         cycles_ff   <= cycles_in;
         irq_ff      <= irq_in;
         bus_mode_ff <= bus_mode_in;
      end
   end

endmodule

// ===== design/twi_master_controller_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready   tdata: item fields, tuser: item kind
// rsp_      out        rsp_tvalid/rsp_tready   tdata: result fields
//
// One transfer in per cycle unless the result register stalls, one result per item; the path is
// an input register, then the register/bus step logic into the result register.
// The register state is updated in the cycle the item leaves the input register.
// Synchronous reset clears the registers, counters and both valid flags.
// While rsp_tready is low a valid result in the result register holds; the input register still
// takes one more item before req_tready drops.

module twi_master_controller_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] target, [15:8] write_data, [31:16] elapsed, [32] power_reduced,
   // [33] rx_restart, [39:34] zero
   input  logic [39:0] req_tdata,
   // [2:0] mode
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] register value, [8] irq_request, [9] tx_valid, [17:10] tx_byte,
   // [18] slave_match, [19] busy_res, [23:20] zero
   output logic [23:0] rsp_tdata
);

   logic                    in_valid_ff;
   twi_mc_pkg::item_type    item_ff;
   logic                    rsp_valid_ff;
   twi_mc_pkg::result_type  result_ff;
   twi_mc_pkg::result_type  result;
   twi_mc_pkg::rx_ctrl_type rx_ctrl;
   twi_mc_pkg::rx_stat_type rx_stat;
   logic                    fire;

   // Item moves on when the result register is free or being drained
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.mode          <= req_tuser;
         item_ff.target        <= req_tdata[7:0];
         item_ff.write_data    <= req_tdata[15:8];
         item_ff.elapsed       <= req_tdata[31:16];
         item_ff.power_reduced <= req_tdata[32];
         item_ff.rx_restart    <= req_tdata[33];
      end
      if (fire) begin
         result_ff <= result;
      end
   end

   twi_mc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (item_ff),
      .rx_stat (rx_stat),
      .rx_ctrl (rx_ctrl),
      .result  (result)
   );

   twi_mc_rx_store u_rx_store (
      .clock   (clock),
      .reset   (reset),
      .rx_ctrl (rx_ctrl),
      .rx_stat (rx_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, result_ff.busy_res, result_ff.slave_match, result_ff.tx_byte,
                        result_ff.tx_valid, result_ff.irq_request, result_ff.reg_value};

endmodule
